FILE: rtl/bc_pkg.sv
// Package: widths, constants and sequencer state type for the binomial coefficient unit.
package bc_pkg;

	localparam int unsigned FieldW = 6;
	localparam int unsigned CoefW = 60;
	localparam int unsigned KW = 5;
	localparam int unsigned DigitW = 8;
	localparam int unsigned ProdW = 72;
	localparam int unsigned Digits = ProdW / DigitW;
	localparam int unsigned DigCntW = 4;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} bc_state_t;

endpackage

FILE: rtl/binomial_coefficient_top.sv
// Binomial coefficient unit: C(n,k) by shared multiply and exact digit-serial divide.
//
// Takes n_total and k_chosen and returns coefficient = C(n,k), 0 when k > n.
// With k reduced to m = min(k, n-k), at most 31, an item with m > 0 runs m
// multiply-and-divide steps; for k = 0, k = n or k > n the unit goes
// straight to the finish state without any step. Each step is a 60x6
// multiply followed by radix-256 digit-serial exact division, over all nine
// digits, by the step index on the same product register. One item is
// in work at a time; the input may take a new item while the previous result
// still waits in the output register.
module binomial_coefficient_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [bc_pkg::FieldW-1:0] n_total,
	input  logic [bc_pkg::FieldW-1:0] k_chosen,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [bc_pkg::CoefW-1:0]  coefficient
);
	import bc_pkg::*;

	bc_state_t            state_q;
	logic [CoefW-1:0]     acc_q;
	logic [ProdW-1:0]     prod_q;
	logic [FieldW-1:0]    base_q;
	logic [KW-1:0]        kk_q;
	logic [KW-1:0]        i_q;
	logic [KW-1:0]        rem_q;
	logic [DigCntW-1:0]   dig_q;
	logic                 out_valid_q;
	logic [CoefW-1:0]     coef_q;

	logic [FieldW-1:0]    n_minus_k;
	logic [FieldW-1:0]    kmin;
	logic [FieldW-1:0]    factor;
	logic [KW-1:0]        rem_nx;
	logic [DigitW-1:0]    qdig;
	logic                 out_free;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign coefficient = coef_q;
	assign out_free    = !out_valid_q || out_ready;

	assign n_minus_k = n_total - k_chosen;
	assign kmin      = (k_chosen > n_minus_k) ? n_minus_k : k_chosen;
	assign factor    = base_q + FieldW'(i_q);

	always_comb begin
		logic [KW:0] t;
		logic [KW-1:0] r;
		r = rem_q;
		qdig = '0;
		for (int j = 0; j < DigitW; j++) begin
			t = {r, prod_q[ProdW-1-j]};
			if (t >= {1'b0, i_q}) begin
				r = KW'(t - {1'b0, i_q});
				qdig[DigitW-1-j] = 1'b1;
			end else begin
				r = t[KW-1:0];
			end
		end
		rem_nx = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			acc_q <= '0;
			prod_q <= '0;
			base_q <= '0;
			kk_q <= '0;
			i_q <= '0;
			rem_q <= '0;
			dig_q <= '0;
			coef_q <= '0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (k_chosen > n_total) begin
							acc_q <= '0;
							state_q <= ST_FIN;
						end else if (k_chosen == '0 || k_chosen == n_total) begin
							acc_q <= CoefW'(1);
							state_q <= ST_FIN;
						end else begin
							acc_q <= CoefW'(1);
							kk_q <= kmin[KW-1:0];
							base_q <= n_total - kmin;
							i_q <= KW'(1);
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_q <= ProdW'(acc_q) * ProdW'(factor);
					rem_q <= '0;
					dig_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					prod_q <= {prod_q[ProdW-DigitW-1:0], qdig};
					rem_q <= rem_nx;
					dig_q <= dig_q + DigCntW'(1);
					if (dig_q == DigCntW'(Digits - 1)) begin
						acc_q <= {prod_q[CoefW-DigitW-1:0], qdig};
						if (i_q == kk_q) begin
							state_q <= ST_FIN;
						end else begin
							i_q <= i_q + KW'(1);
							state_q <= ST_MUL;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						coef_q <= acc_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < i_q)
		else $error("division remainder not below divisor");

	a_mul_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> (i_q != '0 && i_q <= kk_q))
		else $error("step index out of range");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && !out_ready) |=> state_q == ST_FIN)
		else $error("result overwrote a pending output");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q != ST_IDLE)
		else $error("transfer in did not start work");

endmodule
